// File: rtl/ged_pkg.sv
// Shared types, constants and kernel tables of the gradient edge detector.
package ged_pkg;

    localparam int PIX_W        = 8;
    localparam int COORD_W      = 9;
    localparam int MODE_W       = 2;
    localparam int TH_W         = 11;
    localparam int SIDE_W       = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int GRAD_W       = 11;
    localparam int SQ_W         = 20;
    localparam int MAG_W        = 21;
    localparam int TH2_W        = 22;
    localparam int ROOT_LIMIT   = 65536;
    localparam int DEF_MAX_SIDE = 512;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIDE     = 2'd2;

    // Kernel choices
    localparam logic [MODE_W-1:0] MODE_ROBERTS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PREWITT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SOBEL   = 2'd2;

    localparam logic [MODE_W-1:0]     RST_MASK_MODE  = MODE_SOBEL;
    localparam logic [TH_W-1:0]       RST_THRESHOLD  = 11'd100;
    localparam logic [SIDE_W-1:0]     RST_IMAGE_SIDE = 10'd512;
    localparam logic [PIX_W-1:0]      PIX_SAT        = 8'd255;

    typedef logic [8:0][PIX_W-1:0] pix_win_t;
    typedef logic signed [2:0]      kcoef_t;

    // Window taps 0..8 in raster order, rows oldest first
    localparam kcoef_t KERN_X [3][9] = '{
        '{3'sd0, 3'sd0, -3'sd1, 3'sd0, 3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{-3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd0, 3'sd1, -3'sd1, 3'sd0, 3'sd1},
        '{-3'sd1, 3'sd0, 3'sd1, -3'sd2, 3'sd0, 3'sd2, -3'sd1, 3'sd0, 3'sd1}
    };
    localparam kcoef_t KERN_Y [3][9] = '{
        '{-3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd0, 3'sd0, 3'sd0, 3'sd0},
        '{3'sd1, 3'sd1, 3'sd1, 3'sd0, 3'sd0, 3'sd0, -3'sd1, -3'sd1, -3'sd1},
        '{3'sd1, 3'sd2, 3'sd1, 3'sd0, 3'sd0, 3'sd0, -3'sd1, -3'sd2, -3'sd1}
    };

endpackage

// File: rtl/gradient_edge_detector_3x3_core.sv
// Top level of the 3x3 gradient edge detector: line stores, window and sequencer.
//
//  Channel | Ports                                  | Direction
//  --------+----------------------------------------+----------
//  cfg     | cfg_wr_en cfg_index cfg_wdata          | in
//  s_      | s_valid s_ready s_pixel                | in
//  m_      | m_valid m_ready m_out_row m_out_col    | out
//          | m_out_value m_last_in_run              |
//
// One pixel at a time: a new pixel is taken only in idle, after the last one has gone
// through the line store read and any gradient, decision, root and push states.
// Roberts adds the bit-serial root to an interior result; a border result may follow it.
// Reset clears the window, counters and output valid and loads the default configuration;
// the line stores are not cleared. A stalled m_ready holds the sequencer at its push.
module gradient_edge_detector_3x3_core
    import ged_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [PIX_W-1:0]       s_pixel,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COORD_W-1:0]     m_out_row,
    output logic [COORD_W-1:0]     m_out_col,
    output logic [PIX_W-1:0]       m_out_value,
    output logic                   m_last_in_run
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam int CW = AW + 1;
    localparam int SW = (CW > SIDE_W) ? CW : SIDE_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_GRAD, ST_DEC, ST_ROOT, ST_PUSH_I, ST_PUSH_B
    } state_t;

    state_t               state_reg, state_next;
    logic [MODE_W-1:0]    mask_mode_reg;
    logic [TH_W-1:0]      threshold_reg;
    logic [SIDE_W-1:0]    side_cfg_reg;
    logic [TH2_W-1:0]     th2_reg;
    logic [CW-1:0]        row_reg, row_next, col_reg, col_next;
    logic [CW-1:0]        r_reg, r_next, c_reg, c_next;
    logic [PIX_W-1:0]     px_reg, px_next;
    logic [PIX_W-1:0]     val_reg, val_next;
    logic [MAG_W-1:0]     mag_reg, mag_next;
    logic                 go_reg, go_next;
    pix_win_t             win_reg, win_next;
    logic                 m_valid_reg, m_valid_next;
    logic [COORD_W-1:0]   m_row_reg, m_row_next, m_col_reg, m_col_next;
    logic [PIX_W-1:0]     m_val_reg, m_val_next;
    logic                 m_last_reg, m_last_next;

    logic [CW-1:0]        side;
    logic [SW-1:0]        side_ext;
    logic [CW-1:0]        col0, row0, row1, cn, rn;
    logic [MODE_W-1:0]    mode_k;
    logic                 border, interior, slot_free;
    logic                 ram_we;
    logic [PIX_W-1:0]     prev_q, older_q;
    logic                 mag_valid, root_start, root_done;
    logic [MAG_W-1:0]     mag2;
    logic [PIX_W-1:0]     root;

    // Clamp the side to the supported range
    assign side_ext = SW'(side_cfg_reg);
    always_comb begin
        if (side_ext < SW'(3)) begin
            side = CW'(3);
        end else if (side_ext > SW'(MAX_SIDE)) begin
            side = CW'(MAX_SIDE);
        end else begin
            side = CW'(side_ext);
        end
    end

    assign mode_k = mask_mode_reg[1] ? MODE_SOBEL : mask_mode_reg;

    // Position of the arriving pixel, with wrap for a side that shrank
    always_comb begin
        col0 = col_reg;
        row1 = row_reg;
        if (col_reg >= side) begin
            col0 = '0;
            row1 = row_reg + CW'(1);
        end
        row0 = (row1 >= side) ? '0 : row1;
        cn   = col0 + CW'(1);
        rn   = row0;
        if (cn >= side) begin
            cn = '0;
            rn = (row0 + CW'(1) >= side) ? '0 : row0 + CW'(1);
        end
    end

    assign border    = (r_reg == '0) || (c_reg == '0) ||
                       (r_reg == side - CW'(1)) || (c_reg == side - CW'(1));
    assign interior  = (r_reg >= CW'(2)) && (c_reg >= CW'(2));
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign ram_we    = (state_reg == ST_RD);
    assign root_start = (state_reg == ST_DEC) && (mode_k == MODE_ROBERTS);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        px_next      = px_reg;
        val_next     = val_reg;
        mag_next     = mag_reg;
        go_next      = 1'b0;
        win_next     = win_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_row_next   = m_row_reg;
        m_col_next   = m_col_reg;
        m_val_next   = m_val_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    r_next     = row0;
                    c_next     = col0;
                    px_next    = s_pixel;
                    row_next   = rn;
                    col_next   = cn;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                // shift the window and load the new column
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = older_q;
                win_next[3] = win_reg[4];
                win_next[4] = win_reg[5];
                win_next[5] = prev_q;
                win_next[6] = win_reg[7];
                win_next[7] = win_reg[8];
                win_next[8] = px_reg;
                if (interior) begin
                    go_next    = 1'b1;
                    state_next = ST_GRAD;
                end else if (border) begin
                    state_next = ST_PUSH_B;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_GRAD: begin
                if (mag_valid) begin
                    mag_next   = mag2;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (mode_k == MODE_ROBERTS) begin
                    state_next = ST_ROOT;
                end else begin
                    val_next   = (TH2_W'(mag_reg) > th2_reg) ? PIX_SAT : '0;
                    state_next = ST_PUSH_I;
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    val_next   = root;
                    state_next = ST_PUSH_I;
                end
            end
            ST_PUSH_I: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = COORD_W'(r_reg - CW'(1));
                    m_col_next   = COORD_W'(c_reg - CW'(1));
                    m_val_next   = val_reg;
                    m_last_next  = !border;
                    state_next   = border ? ST_PUSH_B : ST_IDLE;
                end
            end
            ST_PUSH_B: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = COORD_W'(r_reg);
                    m_col_next   = COORD_W'(c_reg);
                    m_val_next   = px_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, configuration and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mask_mode_reg <= RST_MASK_MODE;
            threshold_reg <= RST_THRESHOLD;
            side_cfg_reg  <= RST_IMAGE_SIDE;
            row_reg       <= '0;
            col_reg       <= '0;
            go_reg        <= 1'b0;
            win_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            go_reg      <= go_next;
            win_reg     <= win_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_MASK_MODE:      mask_mode_reg <= cfg_wdata[MODE_W-1:0];
                    CFG_EDGE_THRESHOLD: threshold_reg <= cfg_wdata[TH_W-1:0];
                    CFG_IMAGE_SIDE:     side_cfg_reg  <= cfg_wdata[SIDE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
        th2_reg    <= TH2_W'(threshold_reg) * TH2_W'(threshold_reg);
        r_reg      <= r_next;
        c_reg      <= c_next;
        px_reg     <= px_next;
        val_reg    <= val_next;
        mag_reg    <= mag_next;
        m_row_reg  <= m_row_next;
        m_col_reg  <= m_col_next;
        m_val_reg  <= m_val_next;
        m_last_reg <= m_last_next;
    end

    // Line stores: read at accept, write back the shifted column in the next cycle
    ged_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_prev (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (c_reg[AW-1:0]),
        .wdata (px_reg),
        .raddr (col0[AW-1:0]),
        .rdata (prev_q)
    );

    ged_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SIDE)) u_older (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (c_reg[AW-1:0]),
        .wdata (prev_q),
        .raddr (col0[AW-1:0]),
        .rdata (older_q)
    );

    ged_grad u_grad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (go_reg),
        .mode_k    (mode_k),
        .win       (win_reg),
        .mag_valid (mag_valid),
        .mag2      (mag2)
    );

    ged_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .val     (mag_reg),
        .done    (root_done),
        .root    (root)
    );

    assign m_valid       = m_valid_reg;
    assign m_out_row     = m_row_reg;
    assign m_out_col     = m_col_reg;
    assign m_out_value   = m_val_reg;
    assign m_last_in_run = m_last_reg;

    // An accepted beat always moves on to the line store read
    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_RD)
        else $error("accepted beat did not start a line store read");

    // Magnitude arrives only while the sequencer waits for it
    a_mag_in_grad: assert property (@(posedge aclk) disable iff (!aresetn)
        mag_valid |-> state_reg == ST_GRAD)
        else $error("magnitude arrived outside the gradient wait");

    // Root finishes only while the sequencer waits for it
    a_root_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        root_done |-> state_reg == ST_ROOT)
        else $error("root finished outside the root wait");

endmodule

// File: rtl/ged_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
module ged_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/ged_grad.sv
// Gradient pipeline: kernel sums, squares, and squared magnitude.
module ged_grad
    import ged_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [MODE_W-1:0]   mode_k,
    input  pix_win_t            win,
    output logic                mag_valid,
    output logic [MAG_W-1:0]    mag2
);

    logic [2:0]               vld_reg;
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic signed [GRAD_W-1:0] gx_next, gy_next;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic signed [2*GRAD_W-1:0] px2, py2;

    // Form gx and gy from the nine taps
    always_comb begin
        gx_next = '0;
        gy_next = '0;
        for (int i = 0; i < 9; i++) begin
            gx_next = gx_next + GRAD_W'(GRAD_W'(KERN_X[mode_k][i])
                      * GRAD_W'($signed({1'b0, win[i]})));
            gy_next = gy_next + GRAD_W'(GRAD_W'(KERN_Y[mode_k][i])
                      * GRAD_W'($signed({1'b0, win[i]})));
        end
    end

    assign px2 = gx_reg * gx_reg;
    assign py2 = gy_reg * gy_reg;

    // Advance the stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[1:0], start};
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
        sqx_reg <= SQ_W'(px2);
        sqy_reg <= SQ_W'(py2);
        mag_reg <= MAG_W'(sqx_reg) + MAG_W'(sqy_reg);
    end

    assign mag_valid = vld_reg[2];
    assign mag2      = mag_reg;

endmodule

// File: rtl/ged_root.sv
// Iterative integer square root, one result bit per cycle, saturated to 255.
module ged_root
    import ged_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MAG_W-1:0]   val,
    output logic               done,
    output logic [PIX_W-1:0]   root
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [PIX_W-1:0]   res_reg, res_next;
    logic [PIX_W-1:0]   bit_reg, bit_next;
    logic [15:0]        val_reg, val_next;
    logic [PIX_W-1:0]   trial;
    logic [15:0]        trial_sq;

    assign trial    = res_reg | bit_reg;
    assign trial_sq = trial * trial;

    // Try one bit a cycle, highest first
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        bit_next  = bit_reg;
        val_next  = val_reg;
        if (start) begin
            if (val >= MAG_W'(ROOT_LIMIT)) begin
                res_next  = PIX_SAT;
                done_next = 1'b1;
            end else begin
                busy_next = 1'b1;
                res_next  = '0;
                bit_next  = {1'b1, {(PIX_W-1){1'b0}}};
                val_next  = val[15:0];
            end
        end else if (busy_reg) begin
            if (trial_sq <= val_reg) begin
                res_next = trial;
            end
            bit_next = bit_reg >> 1;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        res_reg <= res_next;
        bit_reg <= bit_next;
        val_reg <= val_next;
    end

    assign done = done_reg;
    assign root = res_reg;

endmodule

// File: sim/tb_gradient_edge_detector_3x3_core.sv
// Self-checking testbench for the 3x3 gradient edge detector core.
`timescale 1ns / 1ps

module tb_gradient_edge_detector_3x3_core;
    import ged_pkg::*;

    localparam int SIDE_MAX      = 512;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   value;
        logic               last;
    } pix_result_t;

    typedef struct {
        bit                    wr;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        bit                    typed;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    col;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel;
    logic                  m_valid;
    logic                  m_ready;
    logic [COORD_W-1:0]    m_out_row;
    logic [COORD_W-1:0]    m_out_col;
    logic [PIX_W-1:0]      m_out_value;
    logic                  m_last_in_run;

    gradient_edge_detector_3x3_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_out_value   (m_out_value),
        .m_last_in_run (m_last_in_run)
    );

    // Gradient kernels: Roberts, Prewitt, Sobel; taps in raster order
    int grad_kx [3][9] = '{
        '{ 0, 0, -1, 0, 1, 0, 0, 0, 0 },
        '{ -1, 0, 1, -1, 0, 1, -1, 0, 1 },
        '{ -1, 0, 1, -2, 0, 2, -1, 0, 1 }
    };
    int grad_ky [3][9] = '{
        '{ -1, 0, 0, 0, 1, 0, 0, 0, 0 },
        '{ 1, 1, 1, 0, 0, 0, -1, -1, -1 },
        '{ 1, 2, 1, 0, 0, 0, -1, -2, -1 }
    };

    // Shadow copy of the block's registers and pixel state
    logic [MODE_W-1:0] sh_mode;
    logic [TH_W-1:0]   sh_threshold;
    logic [SIDE_W-1:0] sh_side;
    logic [PIX_W-1:0]  sh_line_prev  [SIDE_MAX];
    logic [PIX_W-1:0]  sh_line_older [SIDE_MAX];
    logic [PIX_W-1:0]  sh_win [9];
    int                sh_row;
    int                sh_col;

    pix_result_t expected_pix_q [$];
    stim_row_t   stim_tbl [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_left;
    int          pixels_sent;

    // Clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Give up after a generous fixed time
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic int clamp_side(logic [SIDE_W-1:0] s);
        int v;
        v = s;
        if (v < 3) v = 3;
        if (v > SIDE_MAX) v = SIDE_MAX;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] window_edge();
        int k;
        int gx;
        int gy;
        longint mag2;
        longint th2;
        int root;
        k = (sh_mode >= MODE_SOBEL) ? 2 : sh_mode;
        gx = 0;
        gy = 0;
        for (int i = 0; i < 9; i++) begin
            gx += grad_kx[k][i] * int'(sh_win[i]);
            gy += grad_ky[k][i] * int'(sh_win[i]);
        end
        mag2 = longint'(gx) * gx + longint'(gy) * gy;
        if (k == 0) begin
            // floor of the root, saturated
            if (mag2 >= 65536) return PIX_SAT;
            root = 0;
            while ((root + 1) * (root + 1) <= mag2) root++;
            return root[PIX_W-1:0];
        end
        th2 = longint'(sh_threshold) * sh_threshold;
        return (mag2 > th2) ? PIX_SAT : '0;
    endfunction

    // Advance the shadow state by one pixel and queue the results it gives
    function automatic void predict_pixel(logic [PIX_W-1:0] px, bit keep);
        int side;
        int r;
        int c;
        bit inner;
        bit border;
        pix_result_t res;
        side = clamp_side(sh_side);
        if (sh_col >= side) begin
            sh_col = 0;
            sh_row++;
        end
        if (sh_row >= side) sh_row = 0;
        r = sh_row;
        c = sh_col;
        sh_win[0] = sh_win[1]; sh_win[1] = sh_win[2];
        sh_win[3] = sh_win[4]; sh_win[4] = sh_win[5];
        sh_win[6] = sh_win[7]; sh_win[7] = sh_win[8];
        sh_win[2] = sh_line_older[c];
        sh_win[5] = sh_line_prev[c];
        sh_win[8] = px;
        sh_line_older[c] = sh_line_prev[c];
        sh_line_prev[c] = px;
        inner = (r >= 2 && c >= 2);
        border = (r == 0 || c == 0 || r == side - 1 || c == side - 1);
        if (keep && inner) begin
            res.row = COORD_W'(r - 1);
            res.col = COORD_W'(c - 1);
            res.value = window_edge();
            res.last = !border;
            expected_pix_q.push_back(res);
        end
        if (keep && border) begin
            res.row = COORD_W'(r);
            res.col = COORD_W'(c);
            res.value = px;
            res.last = 1'b1;
            expected_pix_q.push_back(res);
        end
        sh_col = c + 1;
        if (sh_col >= side) begin
            sh_col = 0;
            sh_row = (r + 1 >= side) ? 0 : r + 1;
        end
    endfunction

    // Offer one pixel beat and wait for it to be taken
    task automatic send_pixel(logic [PIX_W-1:0] px, bit typed,
                              logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
        pix_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(px, !typed);
        if (typed) begin
            res.row = row;
            res.col = col;
            res.value = px;
            res.last = 1'b1;
            expected_pix_q.push_back(res);
        end
        pixels_sent++;
    endtask

    // Drain all results, then let the core go quiet
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_pix_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MASK_MODE:      sh_mode = val[MODE_W-1:0];
            CFG_EDGE_THRESHOLD: sh_threshold = val[TH_W-1:0];
            CFG_IMAGE_SIDE:     sh_side = val[SIDE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic tbl_cfg(logic [CFG_IDX_W-1:0] idx, int val);
        stim_tbl.push_back('{1'b1, idx, CFG_DATA_W'(val), 1'b0, '0, '0});
    endtask

    task automatic tbl_pix(int px);
        stim_tbl.push_back('{1'b0, CFG_MASK_MODE, CFG_DATA_W'(px), 1'b0, '0, '0});
    endtask

    task automatic tbl_pix_typed(int px, int row, int col);
        stim_tbl.push_back('{1'b0, CFG_MASK_MODE, CFG_DATA_W'(px), 1'b1,
                             COORD_W'(row), COORD_W'(col)});
    endtask

    function automatic logic [PIX_W-1:0] gen_pixel(int style);
        case (style)
            0: return PIX_W'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? PIX_SAT : '0;
            default: return PIX_W'(100 + $urandom_range(0, 40));
        endcase
    endfunction

    // Receive side: check each accepted beat, then pick the next ready level
    always @(posedge aclk) begin
        pix_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pix_q.size() == 0) begin
                report_mismatch("unexpected beat, row", m_out_row, -1);
            end else begin
                want = expected_pix_q.pop_front();
                if (m_out_row !== want.row) report_mismatch("out_row", m_out_row, want.row);
                if (m_out_col !== want.col) report_mismatch("out_col", m_out_col, want.col);
                if (m_out_value !== want.value)
                    report_mismatch("out_value", m_out_value, want.value);
                if (m_last_in_run !== want.last)
                    report_mismatch("last_in_run", m_last_in_run, want.last);
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        int side;
        int style;
        int phase;
        int th_pick;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_pixel = '0;
        m_ready = 1'b0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b0;
        hold_left = 0;
        pixels_sent = 0;
        sh_mode = RST_MASK_MODE;
        sh_threshold = RST_THRESHOLD;
        sh_side = RST_IMAGE_SIDE;
        sh_row = 0;
        sh_col = 0;
        for (int i = 0; i < SIDE_MAX; i++) begin
            sh_line_prev[i] = '0;
            sh_line_older[i] = '0;
        end
        for (int i = 0; i < 9; i++) sh_win[i] = '0;

        // Hold reset, then release it
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset defaults on the top border at full side
        tbl_pix_typed(8'hA5, 0, 0);
        tbl_pix_typed(8'h00, 0, 1);
        tbl_pix_typed(8'hFF, 0, 2);
        // Side below minimum acts as 3; counters wrap onto the next row
        tbl_cfg(CFG_IMAGE_SIDE, 0);
        for (int i = 0; i < 3; i++) tbl_pix(0);
        for (int i = 0; i < 3; i++) tbl_pix(255);
        // Roberts with a single bright centre saturates
        tbl_cfg(CFG_MASK_MODE, MODE_ROBERTS);
        for (int i = 0; i < 9; i++) tbl_pix((i == 4) ? 255 : 0);
        // Unused mode acts as Sobel, zero threshold on a flat patch
        tbl_cfg(CFG_MASK_MODE, 3);
        tbl_cfg(CFG_EDGE_THRESHOLD, 0);
        // Oversized side acts as the maximum, then shrinks mid-image
        tbl_cfg(CFG_IMAGE_SIDE, 1023);
        tbl_pix_typed(7, 0, 0);
        tbl_pix_typed(7, 0, 1);
        tbl_cfg(CFG_IMAGE_SIDE, 3);
        for (int i = 0; i < 7; i++) tbl_pix(7);

        foreach (stim_tbl[i]) begin
            if (stim_tbl[i].wr) begin
                settle_idle();
                write_reg(stim_tbl[i].idx, stim_tbl[i].data);
            end else begin
                send_pixel(stim_tbl[i].data[PIX_W-1:0], stim_tbl[i].typed,
                           stim_tbl[i].row, stim_tbl[i].col);
            end
        end

        // Random whole images under changing settings and flow control
        phase = 0;
        while (pixels_sent < 310) begin
            settle_idle();
            case (phase % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                3: begin send_idle_pct = 28; recv_stall_pct = 28; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            th_pick = $urandom_range(0, 5);
            write_reg(CFG_MASK_MODE, CFG_DATA_W'($urandom_range(0, 3)));
            write_reg(CFG_EDGE_THRESHOLD, (th_pick == 0) ? CFG_DATA_W'(0) :
                      (th_pick == 1) ? CFG_DATA_W'(2047) :
                      CFG_DATA_W'($urandom_range(0, 600)));
            side = (phase % 5 == 4) ? 9 : $urandom_range(3, 8);
            write_reg(CFG_IMAGE_SIDE, ($urandom_range(0, 7) == 0 && side == 3) ?
                      CFG_DATA_W'($urandom_range(0, 2)) : CFG_DATA_W'(side));
            style = $urandom_range(0, 2);
            // Stall the output long enough for the core to back up
            if (phase % 5 == 4) hold_req = 1'b1;
            for (int i = 0; i < side * side; i++)
                send_pixel(gen_pixel(($urandom_range(0, 3) == 0) ? 0 : style),
                           1'b0, '0, '0);
            phase++;
        end

        // Drain and finish
        s_valid <= 1'b0;
        while (expected_pix_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ged_pkg.sv
rtl/ged_ram.sv
rtl/ged_grad.sv
rtl/ged_root.sv
rtl/gradient_edge_detector_3x3_core.sv
sim/tb_gradient_edge_detector_3x3_core.sv
